// ===== sv/gpg_pkg.sv =====
// Shared types, constants and codes of the gait phase generator.
`default_nettype none
package gpg_pkg;

  localparam int LEG_COUNT  = 4;
  localparam int PHASE_BITS = 16;
  localparam int REG_W      = 24;
  localparam int NUM_W      = REG_W + 1;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int LEG_IDX_W  = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int REG_COUNT  = 2 + LEG_COUNT;
  localparam int IDX_W      = $clog2(REG_COUNT);
  localparam int ADDR_W     = IDX_W + 2;
  localparam int DATA_W     = 32;

  localparam logic [PHASE_BITS-1:0] PHASE_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [LEG_COUNT-1:0]  LEG_ALL    = '1;

  // gait mode codes
  localparam logic [1:0] MODE_WAVE   = 2'd0;
  localparam logic [1:0] MODE_SWING  = 2'd1;
  localparam logic [1:0] MODE_STANCE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PERIOD  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_STANCE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_OFFSET0 = IDX_W'(2);

  localparam logic [REG_W-1:0] RST_PERIOD = REG_W'(450000);
  localparam logic [REG_W-1:0] RST_STANCE = REG_W'(225000);
  localparam logic [REG_W-1:0] RST_OFFSET_A = REG_W'(0);
  localparam logic [REG_W-1:0] RST_OFFSET_B = REG_W'(225000);

  typedef struct packed {
    logic [1:0]  gait_mode;
    logic [15:0] delta_us;
  } gpg_in_t;

  typedef struct packed {
    logic        leg0_contact;
    logic        leg1_contact;
    logic        leg2_contact;
    logic        leg3_contact;
    logic [15:0] leg0_phase;
    logic [15:0] leg1_phase;
    logic [15:0] leg2_phase;
    logic [15:0] leg3_phase;
  } gpg_out_t;

  typedef struct packed {
    logic [REG_W-1:0]                period;
    logic [REG_W-1:0]                stance;
    logic [LEG_COUNT-1:0][REG_W-1:0] offset;
  } cfg_t;

  // frac: numerator below divisor, returns floor(num * 2^PHASE_BITS / den)
  // otherwise: returns num mod den
  typedef struct packed {
    logic             start;
    logic             frac;
    logic [NUM_W-1:0] num;
    logic [REG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [REG_W-1:0]      rem;
    logic [PHASE_BITS-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/gpg_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module gpg_regs (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [gpg_pkg::ADDR_W-1:0]   paddr,
  input  wire  [gpg_pkg::DATA_W-1:0]   pwdata,
  output logic [gpg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output gpg_pkg::cfg_t                cfg
);
  import gpg_pkg::*;

  cfg_t             cfg_r;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] off_idx;
  logic             is_off;
  logic             wr_en;

  assign idx     = paddr[ADDR_W-1:2];
  assign off_idx = idx - REG_OFFSET0;
  assign is_off  = (idx >= REG_OFFSET0) && (32'(idx) < REG_COUNT);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period <= RST_PERIOD;
      cfg_r.stance <= RST_STANCE;
      for (int i = 0; i < LEG_COUNT; i++) begin
        cfg_r.offset[i] <= ((i % 4) == 1 || (i % 4) == 2) ? RST_OFFSET_B : RST_OFFSET_A;
      end
    end else if (wr_en) begin
      priority if (idx == REG_PERIOD) begin
        cfg_r.period <= pwdata[REG_W-1:0];
      end else if (idx == REG_STANCE) begin
        cfg_r.stance <= pwdata[REG_W-1:0];
      end else if (is_off) begin
        cfg_r.offset[off_idx[LEG_IDX_W-1:0]] <= pwdata[REG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    priority if (idx == REG_PERIOD) begin
      prdata = DATA_W'(cfg_r.period);
    end else if (idx == REG_STANCE) begin
      prdata = DATA_W'(cfg_r.stance);
    end else if (is_off) begin
      prdata = DATA_W'(cfg_r.offset[off_idx[LEG_IDX_W-1:0]]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/gpg_div.sv =====
// Bit-serial restoring divider: remainder or Q0.PHASE_BITS fraction.
`default_nettype none
module gpg_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire gpg_pkg::div_req_t req,
  output gpg_pkg::div_rsp_t rsp
);
  import gpg_pkg::*;

  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [REG_W-1:0]      rem_r;
  logic [NUM_W-1:0]      num_r;
  logic [REG_W-1:0]      den_r;
  logic [PHASE_BITS-1:0] quo_r;

  logic [NUM_W-1:0] trial;
  logic [NUM_W-1:0] diff;
  logic             ge;

  // next numerator bit enters the partial remainder each step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r <= req.den;
        quo_r <= '0;
        if (req.frac) begin
          rem_r <= req.num[REG_W-1:0];
          num_r <= '0;
          cnt_r <= CNT_W'(PHASE_BITS);
        end else begin
          rem_r <= '0;
          num_r <= req.num;
          cnt_r <= CNT_W'(NUM_W);
        end
      end else if (cnt_r != '0) begin
        rem_r  <= ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
        num_r  <= num_r << 1;
        quo_r  <= {quo_r[PHASE_BITS-2:0], ge};
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

// ===== sv/gait_phase_generator.sv =====
// Top level: tick sequencer, per-leg phase evaluation and mode hand-over.
// Offsets and per-leg phases are evaluated only when the requested or settled mode is wave;
// a leg whose phase divisor is zero skips its phase division. Requests are taken one at a
// time, only in the idle state, and the finish state waits on out_stall; every division
// runs one bit per cycle in gpg_div.
// The result sits in an output register, so the next request is taken while it waits.
// Synchronous active-low reset restores registers, position, settled mode and held outputs.
`default_nettype none
module gait_phase_generator (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire gpg_pkg::gpg_in_t      in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output gpg_pkg::gpg_out_t          out_data,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [gpg_pkg::ADDR_W-1:0] paddr,
  input  wire  [gpg_pkg::DATA_W-1:0] pwdata,
  output logic [gpg_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import gpg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POSA, S_POSB, S_OFF, S_WRAP, S_SEL, S_PH, S_FIN
  } state_t;

  cfg_t     cfg;
  div_req_t req_r;
  div_rsp_t rsp;

  gpg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  gpg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req_r),
    .rsp  (rsp)
  );

  state_t                state_r;
  logic [1:0]            mode_r;
  logic [15:0]           delta_r;
  logic [REG_W-1:0]      pos_r;
  logic [1:0]            settled_r;
  logic [LEG_COUNT-1:0]  switch_r;
  logic [LEG_COUNT-1:0]  held_c_r;
  logic [PHASE_BITS-1:0] held_p_r [LEG_COUNT];
  logic [LEG_IDX_W-1:0]  leg_r;
  logic [NUM_W-1:0]      sum_r;
  logic [REG_W-1:0]      s_r;
  logic [LEG_COUNT-1:0]  wave_c_r;
  logic [PHASE_BITS-1:0] wave_p_r [LEG_COUNT];
  logic                  out_valid_r;
  gpg_out_t              out_r;

  // per-leg selection of the current leg's shifted time
  logic                  sel_c;
  logic [REG_W-1:0]      sel_num;
  logic [REG_W-1:0]      sel_den;
  logic                  leg_last;
  logic [LEG_IDX_W-1:0]  leg_inc;
  logic [1:0]            in_mode;
  logic                  slot_free;

  assign in_mode   = (in_data.gait_mode == MODE_UNUSED) ? MODE_SWING : in_data.gait_mode;
  assign leg_last  = (leg_r == LEG_IDX_W'(LEG_COUNT - 1));
  assign leg_inc   = leg_r + LEG_IDX_W'(1);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    sel_c   = s_r < cfg.stance;
    sel_num = sel_c ? s_r : s_r - cfg.stance;
    if (sel_c) begin
      sel_den = cfg.stance;
    end else begin
      sel_den = (cfg.period > cfg.stance) ? cfg.period - cfg.stance : '0;
    end
  end

  // hand-over between old and new mode
  logic [LEG_COUNT-1:0]  fresh_c, set_c, hc_a, sw_a, sw_b, res_c;
  logic [PHASE_BITS-1:0] fresh_p [LEG_COUNT];
  logic [PHASE_BITS-1:0] set_p   [LEG_COUNT];
  logic [PHASE_BITS-1:0] hp_a    [LEG_COUNT];
  logic [PHASE_BITS-1:0] res_p   [LEG_COUNT];
  logic                  chg;
  logic [1:0]            settled_nxt;

  always_comb begin
    chg = mode_r != settled_r;
    for (int i = 0; i < LEG_COUNT; i++) begin
      fresh_c[i] = (mode_r == MODE_WAVE) ? wave_c_r[i] : (mode_r == MODE_STANCE);
      fresh_p[i] = (mode_r == MODE_WAVE) ? wave_p_r[i] : PHASE_HALF;
      set_c[i]   = (settled_r == MODE_WAVE) ? wave_c_r[i] : (settled_r == MODE_STANCE);
      set_p[i]   = (settled_r == MODE_WAVE) ? wave_p_r[i] : PHASE_HALF;
      hp_a[i]    = chg ? set_p[i] : held_p_r[i];
    end
    sw_a = (chg && switch_r == '0) ? LEG_ALL : switch_r;
    if (!chg) begin
      hc_a = held_c_r;
    end else if (mode_r == MODE_STANCE && settled_r == MODE_SWING) begin
      hc_a = LEG_ALL;
    end else if (mode_r == MODE_SWING && settled_r == MODE_STANCE) begin
      hc_a = '0;
    end else begin
      hc_a = set_c;
    end
    sw_b  = sw_a;
    res_c = fresh_c;
    for (int i = 0; i < LEG_COUNT; i++) begin
      res_p[i] = fresh_p[i];
      if (sw_a != '0) begin
        if (fresh_c[i] == hc_a[i]) begin
          sw_b[i] = 1'b0;
        end else begin
          res_c[i] = hc_a[i];
          res_p[i] = hp_a[i];
        end
      end
    end
    settled_nxt = (sw_a != '0 && sw_b == '0) ? mode_r : settled_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r.start <= 1'b0;
      pos_r       <= '0;
      settled_r   <= MODE_SWING;
      switch_r    <= '0;
      held_c_r    <= '0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        held_p_r[i] <= PHASE_HALF;
      end
      out_valid_r <= 1'b0;
    end else begin
      req_r.start <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r      <= in_mode;
            delta_r     <= in_data.delta_us;
            req_r.start <= 1'b1;
            req_r.frac  <= 1'b0;
            req_r.num   <= NUM_W'(pos_r);
            req_r.den   <= cfg.period;
            state_r     <= S_POSA;
          end
        end
        S_POSA: begin
          if (rsp.done) begin
            req_r.start <= 1'b1;
            req_r.frac  <= 1'b0;
            req_r.num   <= NUM_W'(rsp.rem) + NUM_W'(delta_r);
            req_r.den   <= cfg.period;
            state_r     <= S_POSB;
          end
        end
        S_POSB: begin
          if (rsp.done) begin
            pos_r <= (cfg.period == '0) ? '0 : rsp.rem;
            leg_r <= '0;
            if (mode_r == MODE_WAVE || settled_r == MODE_WAVE) begin
              req_r.start <= 1'b1;
              req_r.frac  <= 1'b0;
              req_r.num   <= NUM_W'(cfg.offset[0]);
              req_r.den   <= cfg.period;
              state_r     <= S_OFF;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_OFF: begin
          if (rsp.done) begin
            sum_r   <= {1'b0, pos_r} + {1'b0, cfg.period} - {1'b0, rsp.rem};
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (cfg.period == '0) begin
            s_r <= '0;
          end else if (sum_r >= {1'b0, cfg.period}) begin
            s_r <= REG_W'(sum_r - {1'b0, cfg.period});
          end else begin
            s_r <= sum_r[REG_W-1:0];
          end
          state_r <= S_SEL;
        end
        S_SEL: begin
          wave_c_r[leg_r] <= sel_c;
          if (sel_den != '0) begin
            req_r.start <= 1'b1;
            req_r.frac  <= 1'b1;
            req_r.num   <= NUM_W'(sel_num);
            req_r.den   <= sel_den;
            state_r     <= S_PH;
          end else begin
            // zero divisor: phase reads as zero
            wave_p_r[leg_r] <= '0;
            if (leg_last) begin
              state_r <= S_FIN;
            end else begin
              leg_r       <= leg_inc;
              req_r.start <= 1'b1;
              req_r.frac  <= 1'b0;
              req_r.num   <= NUM_W'(cfg.offset[leg_inc]);
              req_r.den   <= cfg.period;
              state_r     <= S_OFF;
            end
          end
        end
        S_PH: begin
          if (rsp.done) begin
            wave_p_r[leg_r] <= rsp.quo;
            if (leg_last) begin
              state_r <= S_FIN;
            end else begin
              leg_r       <= leg_inc;
              req_r.start <= 1'b1;
              req_r.frac  <= 1'b0;
              req_r.num   <= NUM_W'(cfg.offset[leg_inc]);
              req_r.den   <= cfg.period;
              state_r     <= S_OFF;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            switch_r  <= sw_b;
            held_c_r  <= hc_a;
            settled_r <= settled_nxt;
            for (int i = 0; i < LEG_COUNT; i++) begin
              held_p_r[i] <= hp_a[i];
            end
            out_r.leg0_contact <= res_c[0];
            out_r.leg1_contact <= res_c[1];
            out_r.leg2_contact <= res_c[2];
            out_r.leg3_contact <= res_c[3];
            out_r.leg0_phase   <= res_p[0];
            out_r.leg1_phase   <= res_p[1];
            out_r.leg2_phase   <= res_p[2];
            out_r.leg3_phase   <= res_p[3];
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for gait_phase_generator: directed tick table, then random phases.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gpg_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 300;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_TICKS  = 166;
  localparam int LONG_HOLD    = 3000;
  localparam int REPORT_MAX   = 10;

  localparam gpg_out_t SWING_HALF  = {4'b0000, {LEG_COUNT{PHASE_HALF}}};
  localparam gpg_out_t STANCE_HALF = {4'b1111, {LEG_COUNT{PHASE_HALF}}};

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] delta;
    bit          typed;
    gpg_out_t    want;
  } tick_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  gpg_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  gpg_out_t             out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  gait_phase_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gait state mirror
  logic [REG_W-1:0]            period_m;
  logic [REG_W-1:0]            stance_m;
  logic [LEG_COUNT-1:0][REG_W-1:0] offset_m;
  logic [REG_W-1:0]            position_m;
  logic [1:0]                  settled_m;
  logic [LEG_COUNT-1:0]        switching_m;
  logic [LEG_COUNT-1:0]        held_contact_m;
  logic [LEG_COUNT-1:0][15:0]  held_phase_m;

  gpg_out_t  pending_legs[$];
  tick_row_t tick_table[$];

  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_req;
  int hold_left;
  int idle_cycles;
  int fail_count;
  int ticks_sent;
  int results_seen;
  int mode_changes;
  int settings_used;
  logic [1:0] last_mode;

  function automatic logic [15:0] phase_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return 16'd0;
    q = (num << PHASE_BITS) / den;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  function automatic void legs_eval(input logic [1:0] mode,
                                    output logic [LEG_COUNT-1:0] c,
                                    output logic [LEG_COUNT-1:0][15:0] p);
    longint unsigned per;
    longint unsigned st;
    longint unsigned s;
    longint unsigned off;
    per = period_m;
    st  = stance_m;
    c   = '0;
    for (int i = 0; i < LEG_COUNT; i++) begin
      if (mode == MODE_WAVE) begin
        s = 0;
        if (per != 0) begin
          off = longint'(offset_m[i]) % per;
          s = (longint'(position_m) % per + per - off) % per;
        end
        if (s < st) begin
          c[i] = 1'b1;
          p[i] = phase_ratio(s, st);
        end else begin
          p[i] = phase_ratio(s - st, (per > st) ? per - st : 0);
        end
      end else begin
        c[i] = (mode == MODE_STANCE);
        p[i] = PHASE_HALF;
      end
    end
  endfunction

  function automatic gpg_out_t gait_predict(gpg_in_t t);
    logic [1:0]                 mode;
    logic [LEG_COUNT-1:0]       c;
    logic [LEG_COUNT-1:0][15:0] p;
    longint unsigned            pos;
    mode = (t.gait_mode == MODE_UNUSED) ? MODE_SWING : t.gait_mode;
    if (period_m == 0) begin
      position_m = '0;
    end else begin
      pos = (longint'(position_m) % period_m + t.delta_us) % period_m;
      position_m = pos[REG_W-1:0];
    end
    legs_eval(mode, c, p);
    if (mode != settled_m) begin
      if (switching_m == '0) switching_m = LEG_ALL;
      // held values come from the old mode
      legs_eval(settled_m, held_contact_m, held_phase_m);
      if (mode == MODE_STANCE && settled_m == MODE_SWING) held_contact_m = LEG_ALL;
      else if (mode == MODE_SWING && settled_m == MODE_STANCE) held_contact_m = '0;
    end
    if (switching_m != '0) begin
      for (int i = 0; i < LEG_COUNT; i++) begin
        if (c[i] == held_contact_m[i]) begin
          switching_m[i] = 1'b0;
        end else begin
          c[i] = held_contact_m[i];
          p[i] = held_phase_m[i];
        end
      end
      if (switching_m == '0) settled_m = mode;
    end
    return {c[0], c[1], c[2], c[3], p[0], p[1], p[2], p[3]};
  endfunction

  function automatic void split_legs(input gpg_out_t r, output logic [3:0] c,
                                     output logic [3:0][15:0] p);
    c = {r.leg3_contact, r.leg2_contact, r.leg1_contact, r.leg0_contact};
    p = {r.leg3_phase, r.leg2_phase, r.leg1_phase, r.leg0_phase};
  endfunction

  task automatic check_result(gpg_out_t got);
    gpg_out_t         want;
    logic [3:0]       wc, gc;
    logic [3:0][15:0] wp, gp;
    results_seen++;
    if (pending_legs.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0t: result with no request pending: %h", $realtime, got);
      return;
    end
    want = pending_legs.pop_front();
    split_legs(want, wc, wp);
    split_legs(got, gc, gp);
    for (int i = 0; i < LEG_COUNT; i++) begin
      if (wc[i] !== gc[i]) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: result %0d leg%0d contact exp %0d got %0d", $realtime,
                   results_seen, i, wc[i], gc[i]);
      end
      if (wp[i] !== gp[i]) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: result %0d leg%0d phase exp %0d got %0d", $realtime,
                   results_seen, i, wp[i], gp[i]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) check_result(out_data);
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d requests pending", $realtime,
               IDLE_LIMIT, pending_legs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [REG_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PERIOD) period_m = v;
    else if (idx == REG_STANCE) stance_m = v;
    else offset_m[idx - REG_OFFSET0] = v;
  endtask

  task automatic apply_setting(int k);
    logic [REG_W-1:0]                per;
    logic [REG_W-1:0]                st;
    logic [LEG_COUNT-1:0][REG_W-1:0] off;
    case (k)
      1:       begin per = 1000;     st = 1;       off = {24'd999, 24'd500, 24'd250, 24'd0}; end
      2:       begin per = 1000;     st = 999;     off = {24'd0, 24'd1, 24'd1000, 24'd10000000}; end
      3:       begin per = 10000000; st = 9999999;
                     off = {24'd7500000, 24'd5000000, 24'd2500000, 24'd0}; end
      4:       begin per = 2000;     st = 500;     off = {24'd1999, 24'd3000, 24'd9999999, 24'd10000000}; end
      // stance equal to and above the period: wave legs stay in stance
      5:       begin per = 5000;     st = 5000;    off = {24'd4999, 24'd2500, 24'd1, 24'd0}; end
      6:       begin per = 1000;     st = 9999999; off = {24'd999, 24'd1, 24'd0, 24'd10000000}; end
      default: begin per = 120000;   st = 60000;   off = {24'd90000, 24'd30000, 24'd60000, 24'd0}; end
    endcase
    reg_write(REG_PERIOD, per);
    reg_write(REG_STANCE, st);
    for (int i = 0; i < LEG_COUNT; i++) reg_write(REG_OFFSET0 + IDX_W'(i), off[i]);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_legs.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(logic [1:0] mode, logic [15:0] delta, bit typed, gpg_out_t want);
    int       gap;
    gpg_in_t  t;
    gpg_out_t pred;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    t.gait_mode = mode;
    t.delta_us  = delta;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = gait_predict(t);
    pending_legs.push_back(typed ? want : pred);
    ticks_sent++;
    if (mode != last_mode) mode_changes++;
    last_mode = mode;
  endtask

  function automatic void add_row(logic [1:0] mode, logic [15:0] delta, bit typed,
                                  gpg_out_t want);
    tick_row_t r;
    r.mode  = mode;
    r.delta = delta;
    r.typed = typed;
    r.want  = want;
    tick_table.push_back(r);
  endfunction

  function automatic logic [15:0] pick_delta();
    int unsigned span;
    span = (period_m / 16 > 65535) ? 65535 : period_m / 16 + 1;
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(span));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(9))
      6:       return MODE_SWING;
      7:       return MODE_STANCE;
      8:       return MODE_UNUSED;
      9:       return 2'($urandom_range(3));
      default: return MODE_WAVE;
    endcase
  endfunction

  initial begin
    int         run_left;
    logic [1:0] run_mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    idle_cycles = 0;
    fail_count = 0;
    ticks_sent = 0;
    results_seen = 0;
    mode_changes = 0;
    settings_used = 1;
    last_mode = MODE_SWING;
    run_left = 0;
    run_mode = MODE_WAVE;

    period_m = RST_PERIOD;
    stance_m = RST_STANCE;
    offset_m = {RST_OFFSET_A, RST_OFFSET_B, RST_OFFSET_B, RST_OFFSET_A};
    position_m = '0;
    settled_m = MODE_SWING;
    switching_m = '0;
    held_contact_m = '0;
    held_phase_m = {LEG_COUNT{PHASE_HALF}};

    // fixed modes read straight off; wave and hand-over rows go through the predictor
    add_row(MODE_SWING,  16'd0,     1, SWING_HALF);
    add_row(MODE_UNUSED, 16'hFFFF,  1, SWING_HALF);
    add_row(MODE_STANCE, 16'd0,     1, STANCE_HALF);
    add_row(MODE_STANCE, 16'hFFFF,  1, STANCE_HALF);
    add_row(MODE_UNUSED, 16'd0,     1, SWING_HALF);
    add_row(MODE_WAVE,   16'd0,     0, '0);
    for (int i = 0; i < 6; i++) add_row(MODE_WAVE, 16'hFFFF, 0, '0);
    add_row(MODE_STANCE, 16'd0,     0, '0);
    add_row(MODE_STANCE, 16'd40000, 0, '0);
    add_row(MODE_WAVE,   16'd0,     0, '0);
    add_row(MODE_WAVE,   16'd30000, 0, '0);
    add_row(MODE_SWING,  16'hFFFF,  0, '0);
    add_row(MODE_WAVE,   16'hFFFF,  0, '0);
    add_row(MODE_STANCE, 16'd1,     0, '0);
    add_row(MODE_SWING,  16'd2,     0, '0);
    add_row(MODE_WAVE,   16'd12345, 0, '0);
    add_row(MODE_WAVE,   16'h5555,  0, '0);
    add_row(MODE_UNUSED, 16'hAAAA,  0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (tick_table[i])
      send_tick(tick_table[i].mode, tick_table[i].delta, tick_table[i].typed,
                tick_table[i].want);
    drain_requests();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_requests();
      if (ph > 0) begin
        apply_setting(ph);
        settings_used++;
      end
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 76; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 76; end
        default: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (ph == 2 && n == 40) hold_req = LONG_HOLD;
        if (ph == 3 && n == 80) drain_requests();
        if (run_left == 0) begin
          run_mode = pick_mode();
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        send_tick(run_mode, pick_delta(), 0, '0);
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_legs.size() != 0) begin
      fail_count += pending_legs.size();
      $display("%0d requests never produced a result", pending_legs.size());
    end
    $display("Covered %0d ticks, %0d mode changes, %0d register settings;",
             ticks_sent, mode_changes, settings_used);
    $display("%0d results checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
